>>> rtl/core/pab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_pkg
// Shared types and constants for the best-fit pool allocator.
// ----------------------------------------------------------------------------
package pab_pkg;

    localparam int FREE_ENTRIES_DEF = 32;
    localparam int LIVE_ENTRIES_DEF = 32;
    localparam int OFFSET_BITS_DEF  = 20;

    localparam int BYTE_W  = 21;  // byte_count / block_offset / pool length
    localparam int ALIGN_W = 13;
    localparam int REM_W   = ALIGN_W + 1;
    localparam int NEED_W  = BYTE_W + 1;  // rounded size can pass 2^21
    localparam int GOFF_W  = 20;

    localparam logic [BYTE_W-1:0] POOL_LEN_RST = 21'd65536;

    // register index (paddr[2])
    localparam logic REG_POOL_LEN = 1'b0;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_ZERO    = 3'd1,
        ST_OOM     = 3'd2,
        ST_FREED   = 3'd3,
        ST_IGNORED = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic                func;
        logic [BYTE_W-1:0]   byte_count;
        logic [ALIGN_W-1:0]  align;
        logic [BYTE_W-1:0]   block_offset;
    } t_in_word;

    typedef struct packed {
        logic [GOFF_W-1:0] granted_offset;
        t_status           status;
    } t_out_word;

    typedef struct packed {
        logic    load_in;
        logic    div_start;
        logic    need_ld;
        logic    scan_start;
        logic    key_ld;
        logic    commit_alloc;
        logic    commit_free;
        logic    res_ld;
        t_status res_status;
    } t_pab_cmd;

    typedef struct packed {
        logic func;
        logic zero_req;
        logic free_ok;
        logic div_done;
        logic scan_done;
        logic bf_hit;
        logic oom;
        logic live_slot_ok;
        logic free_match;
        logic free_slot_ok;
    } t_pab_sts;

endpackage

>>> rtl/core/pab_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_ctrl
// Request sequencer: rounding, table scans, commit and result handoff.
// ----------------------------------------------------------------------------
module pab_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  pab_pkg::t_pab_sts  i_sts,
    output pab_pkg::t_pab_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_NEED,
        S_SCAN1,
        S_SCAN2,
        S_DONE
    } t_state;

    t_state           r_state;
    pab_pkg::t_status r_status;
    logic             r_do_alloc;
    logic             r_do_free;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = r_status;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.div_start  = (i_sts.func == pab_pkg::FUNC_ALLOC) && !i_sts.zero_req;
                o_cmd.scan_start = (i_sts.func == pab_pkg::FUNC_FREE) && i_sts.free_ok;
            end
            S_DIV: begin
                o_cmd.need_ld = i_sts.div_done;
            end
            S_NEED: begin
                o_cmd.scan_start = 1'b1;
            end
            S_SCAN1: begin
                if (i_sts.scan_done && i_sts.func == pab_pkg::FUNC_ALLOC &&
                    (i_sts.bf_hit || !i_sts.oom)) begin
                    o_cmd.key_ld     = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_SCAN2: begin
            end
            S_DONE: begin
                o_cmd.res_ld       = out_free;
                o_cmd.commit_alloc = out_free && r_do_alloc;
                o_cmd.commit_free  = out_free && r_do_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_status    <= pab_pkg::ST_GRANTED;
            r_do_alloc  <= 1'b0;
            r_do_free   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_sts.func == pab_pkg::FUNC_ALLOC) begin
                        if (i_sts.zero_req) begin
                            r_status <= pab_pkg::ST_ZERO;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else if (i_sts.free_ok) begin
                        r_state <= S_SCAN1;
                    end else begin
                        r_status <= pab_pkg::ST_IGNORED;
                        r_state  <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (i_sts.div_done) begin
                        r_state <= S_NEED;
                    end
                end
                S_NEED: begin
                    r_state <= S_SCAN1;
                end
                S_SCAN1: begin
                    if (i_sts.scan_done) begin
                        if (i_sts.func == pab_pkg::FUNC_ALLOC) begin
                            if (i_sts.bf_hit || !i_sts.oom) begin
                                r_state <= S_SCAN2;
                            end else begin
                                r_status <= pab_pkg::ST_OOM;
                                r_state  <= S_DONE;
                            end
                        end else begin
                            r_state <= S_DONE;
                            if (i_sts.free_match && i_sts.free_slot_ok) begin
                                r_status  <= pab_pkg::ST_FREED;
                                r_do_free <= 1'b1;
                            end else if (i_sts.free_match) begin
                                r_status <= pab_pkg::ST_FULL;
                            end else begin
                                r_status <= pab_pkg::ST_IGNORED;
                            end
                        end
                    end
                end
                S_SCAN2: begin
                    if (i_sts.scan_done) begin
                        r_state <= S_DONE;
                        if (i_sts.live_slot_ok) begin
                            r_status   <= pab_pkg::ST_GRANTED;
                            r_do_alloc <= 1'b1;
                        end else begin
                            r_status <= pab_pkg::ST_FULL;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_do_alloc  <= 1'b0;
                        r_do_free   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_one_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit_alloc && o_cmd.commit_free))
        else $error("alloc and free commit together");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_ld |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a held word");

    a_res_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_ld |=> o_out_valid)
        else $error("loaded result not presented");
`endif

endmodule

>>> rtl/core/pab_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pab_dp
// Datapath: remainder unit, free/live tables, scan trackers, top pointer.
// ----------------------------------------------------------------------------
module pab_dp #(
    parameter int FREE_ENTRIES = pab_pkg::FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES = pab_pkg::LIVE_ENTRIES_DEF,
    parameter int OFFSET_BITS  = pab_pkg::OFFSET_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pab_pkg::t_pab_cmd              i_cmd,
    output pab_pkg::t_pab_sts              o_sts,
    input  pab_pkg::t_in_word              i_in_word,
    input  logic [pab_pkg::BYTE_W-1:0]     i_pool_len,
    output pab_pkg::t_out_word             o_out_word
);

    localparam int FIDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int LIDX_W = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
    localparam int MAX_N  = (FREE_ENTRIES > LIVE_ENTRIES) ? FREE_ENTRIES : LIVE_ENTRIES;
    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int NEED_W = pab_pkg::NEED_W;
    localparam int TOP_W  = OFFSET_BITS + 1;
    localparam int SUM_W  = ((TOP_W > NEED_W) ? TOP_W : NEED_W) + 1;
    localparam int KEY_W  = (OFFSET_BITS > pab_pkg::BYTE_W) ? OFFSET_BITS : pab_pkg::BYTE_W;
    localparam int DIV_STEPS = pab_pkg::BYTE_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);

    pab_pkg::t_in_word r_in;
    pab_pkg::t_out_word r_out;

    // tables: data in arrays, valid bits in flops
    logic [OFFSET_BITS-1:0] r_free_off  [FREE_ENTRIES];
    logic [NEED_W-1:0]      r_free_size [FREE_ENTRIES];
    logic [FREE_ENTRIES-1:0] r_free_vld;
    logic [OFFSET_BITS-1:0] r_live_off  [LIVE_ENTRIES];
    logic [NEED_W-1:0]      r_live_size [LIVE_ENTRIES];
    logic [LIVE_ENTRIES-1:0] r_live_vld;

    logic [TOP_W-1:0]       r_top;
    logic [NEED_W-1:0]      r_need;
    logic [OFFSET_BITS-1:0] r_key_off;
    logic                   r_reuse;
    logic [FIDX_W-1:0]      r_reuse_idx;

    // remainder unit
    logic [pab_pkg::REM_W-1:0]   r_rem;
    logic [pab_pkg::BYTE_W-1:0]  r_dsh;
    logic [DCNT_W-1:0]           r_dcnt;
    logic                        r_div_act;
    logic                        r_div_done;
    logic [pab_pkg::ALIGN_W-1:0] align_eff;
    logic [pab_pkg::REM_W-1:0]   rem_try;
    logic [pab_pkg::REM_W-1:0]   rem_nxt;

    // scan engine
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_cmp_idx;
    logic                   r_scan_act;
    logic                   r_cmp_act;
    logic                   r_scan_done;
    logic [OFFSET_BITS-1:0] r_frd_off;
    logic [NEED_W-1:0]      r_frd_size;
    logic                   r_frd_vld;
    logic [OFFSET_BITS-1:0] r_lrd_off;
    logic [NEED_W-1:0]      r_lrd_size;
    logic                   r_lrd_vld;
    logic                   f_en;
    logic                   l_en;

    // trackers
    logic                   r_lm_hit;
    logic [LIDX_W-1:0]      r_lm_idx;
    logic [NEED_W-1:0]      r_lm_size;
    logic                   r_le_hit;
    logic [LIDX_W-1:0]      r_le_idx;
    logic                   r_fm_hit;
    logic [FIDX_W-1:0]      r_fm_idx;
    logic                   r_fe_hit;
    logic [FIDX_W-1:0]      r_fe_idx;
    logic                   r_bf_hit;
    logic [FIDX_W-1:0]      r_bf_idx;
    logic [NEED_W-1:0]      r_bf_size;
    logic [OFFSET_BITS-1:0] r_bf_off;

    logic [SUM_W-1:0]       lim_pool;
    logic [SUM_W-1:0]       lim_cap;
    logic [SUM_W-1:0]       limit;
    logic [KEY_W-1:0]       live_key;
    logic [KEY_W-1:0]       boff_key;
    logic [NEED_W-1:0]      bytes_ext;
    logic                   bf_better;
    logic [LIDX_W-1:0]      l_wr;
    logic [FIDX_W-1:0]      f_wr;

    assign align_eff = (r_in.align == '0) ? pab_pkg::ALIGN_W'(1) : r_in.align;
    assign rem_try   = {r_rem[pab_pkg::REM_W-2:0], r_dsh[pab_pkg::BYTE_W-1]};
    assign rem_nxt   = (rem_try >= pab_pkg::REM_W'(align_eff)) ?
                       rem_try - pab_pkg::REM_W'(align_eff) : rem_try;

    assign lim_pool = SUM_W'(i_pool_len);
    assign lim_cap  = SUM_W'(1) << OFFSET_BITS;
    assign limit    = (lim_pool < lim_cap) ? lim_pool : lim_cap;

    assign boff_key  = KEY_W'(r_in.block_offset);
    assign live_key  = (r_in.func == pab_pkg::FUNC_FREE) ? boff_key : KEY_W'(r_key_off);
    assign bytes_ext = NEED_W'(r_in.byte_count);

    assign f_en = r_cmp_act && (r_cmp_idx < CNT_W'(FREE_ENTRIES));
    assign l_en = r_cmp_act && (r_cmp_idx < CNT_W'(LIVE_ENTRIES));

    assign bf_better = (r_frd_size >= r_need) &&
                       (!r_bf_hit || (r_frd_size < r_bf_size) ||
                        ((r_frd_size == r_bf_size) && (r_frd_off < r_bf_off)));

    assign l_wr = r_lm_hit ? r_lm_idx : r_le_idx;
    assign f_wr = r_fm_hit ? r_fm_idx : r_fe_idx;

    always_comb begin
        o_sts              = '0;
        o_sts.func         = r_in.func;
        o_sts.zero_req     = (r_in.byte_count == '0);
        o_sts.free_ok      = (r_in.byte_count != '0) &&
                             (SUM_W'(r_in.block_offset) < limit);
        o_sts.div_done     = r_div_done;
        o_sts.scan_done    = r_scan_done;
        o_sts.bf_hit       = r_bf_hit;
        o_sts.oom          = (SUM_W'(r_top) + SUM_W'(r_need)) > limit;
        o_sts.live_slot_ok = r_lm_hit || r_le_hit;
        o_sts.free_match   = r_lm_hit && (r_lm_size == bytes_ext);
        o_sts.free_slot_ok = r_fm_hit || r_fe_hit;
    end

    assign o_out_word = r_out;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_act   <= 1'b0;
            r_div_done  <= 1'b0;
            r_scan_act  <= 1'b0;
            r_cmp_act   <= 1'b0;
            r_scan_done <= 1'b0;
            r_top       <= '0;
            r_free_vld  <= '0;
            r_live_vld  <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_div_act  <= 1'b1;
                r_div_done <= 1'b0;
            end else if (r_div_act && r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                r_div_act  <= 1'b0;
                r_div_done <= 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_act  <= 1'b1;
                r_cmp_act   <= 1'b0;
                r_scan_done <= 1'b0;
            end else begin
                r_cmp_act <= r_scan_act;
                if (r_scan_act && r_cnt == CNT_W'(MAX_N - 1)) begin
                    r_scan_act <= 1'b0;
                end
                if (r_cmp_act && r_cmp_idx == CNT_W'(MAX_N - 1)) begin
                    r_scan_done <= 1'b1;
                end
            end

            if (i_cmd.commit_alloc) begin
                r_live_vld[l_wr] <= 1'b1;
                if (r_reuse) begin
                    r_free_vld[r_reuse_idx] <= 1'b0;
                end else begin
                    r_top <= TOP_W'(SUM_W'(r_top) + SUM_W'(r_need));
                end
            end
            if (i_cmd.commit_free) begin
                r_live_vld[r_lm_idx] <= 1'b0;
                r_free_vld[f_wr]     <= 1'b1;
            end
        end
    end

    // payload, table data and scan trackers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end

        if (i_cmd.div_start) begin
            r_rem  <= '0;
            r_dsh  <= r_in.byte_count;
            r_dcnt <= '0;
        end else if (r_div_act) begin
            r_rem  <= rem_nxt;
            r_dsh  <= r_dsh << 1;
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end

        // round up: add (align - rem) unless exact
        if (i_cmd.need_ld) begin
            r_need <= bytes_ext + ((r_rem != '0) ?
                      NEED_W'(align_eff) - NEED_W'(r_rem) : NEED_W'(0));
        end

        if (i_cmd.key_ld) begin
            r_key_off   <= r_bf_hit ? r_bf_off : r_top[OFFSET_BITS-1:0];
            r_reuse     <= r_bf_hit;
            r_reuse_idx <= r_bf_idx;
        end

        if (i_cmd.scan_start) begin
            r_cnt <= '0;
        end else if (r_scan_act) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        r_cmp_idx  <= r_cnt;
        r_frd_off  <= r_free_off[r_cnt[FIDX_W-1:0]];
        r_frd_size <= r_free_size[r_cnt[FIDX_W-1:0]];
        r_frd_vld  <= r_free_vld[r_cnt[FIDX_W-1:0]];
        r_lrd_off  <= r_live_off[r_cnt[LIDX_W-1:0]];
        r_lrd_size <= r_live_size[r_cnt[LIDX_W-1:0]];
        r_lrd_vld  <= r_live_vld[r_cnt[LIDX_W-1:0]];

        if (i_cmd.scan_start) begin
            r_lm_hit <= 1'b0;
            r_le_hit <= 1'b0;
            r_fm_hit <= 1'b0;
            r_fe_hit <= 1'b0;
            r_bf_hit <= 1'b0;
        end else begin
            if (l_en) begin
                if (r_lrd_vld) begin
                    if (!r_lm_hit && KEY_W'(r_lrd_off) == live_key) begin
                        r_lm_hit  <= 1'b1;
                        r_lm_idx  <= r_cmp_idx[LIDX_W-1:0];
                        r_lm_size <= r_lrd_size;
                    end
                end else if (!r_le_hit) begin
                    r_le_hit <= 1'b1;
                    r_le_idx <= r_cmp_idx[LIDX_W-1:0];
                end
            end
            if (f_en) begin
                if (r_frd_vld) begin
                    if (!r_fm_hit && KEY_W'(r_frd_off) == boff_key &&
                        r_frd_size == bytes_ext) begin
                        r_fm_hit <= 1'b1;
                        r_fm_idx <= r_cmp_idx[FIDX_W-1:0];
                    end
                    if (bf_better) begin
                        r_bf_hit  <= 1'b1;
                        r_bf_idx  <= r_cmp_idx[FIDX_W-1:0];
                        r_bf_size <= r_frd_size;
                        r_bf_off  <= r_frd_off;
                    end
                end else if (!r_fe_hit) begin
                    r_fe_hit <= 1'b1;
                    r_fe_idx <= r_cmp_idx[FIDX_W-1:0];
                end
            end
        end

        if (i_cmd.commit_alloc) begin
            r_live_off[l_wr]  <= r_key_off;
            r_live_size[l_wr] <= r_need;
        end
        if (i_cmd.commit_free) begin
            r_free_off[f_wr]  <= OFFSET_BITS'(r_in.block_offset);
            r_free_size[f_wr] <= bytes_ext;
        end

        if (i_cmd.res_ld) begin
            r_out.status         <= i_cmd.res_status;
            r_out.granted_offset <= (i_cmd.res_status == pab_pkg::ST_GRANTED) ?
                                    pab_pkg::GOFF_W'(r_key_off) : '0;
        end
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_done |-> (!r_scan_act && !r_cmp_act))
        else $error("scan flagged done while still running");

    a_div_scan_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_div_act && r_scan_act))
        else $error("remainder unit and scan active together");
`endif

endmodule

>>> rtl/core/pool_allocator_best_fit.sv
`timescale 1ns / 1ps
// Allocate: a 21-step remainder unit rounds the size, then two scans read one table
//   entry per cycle, each over the larger table depth.
// Out of memory skips the second scan. Free takes one scan; zero or rejected
//   requests take none.
// Throughput: one word at a time; the next word is taken while a result waits.
// Reset: tables empty (valid flops cleared at once), top pointer 0, pool length 65536.
// ----------------------------------------------------------------------------
// pool_allocator_best_fit
// Bump allocator with a best-fit free table and a live-block table.
// ----------------------------------------------------------------------------
module pool_allocator_best_fit #(
    parameter int FREE_ENTRIES = pab_pkg::FREE_ENTRIES_DEF,
    parameter int LIVE_ENTRIES = pab_pkg::LIVE_ENTRIES_DEF,
    parameter int OFFSET_BITS  = pab_pkg::OFFSET_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pab_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pab_pkg::t_out_word  o_out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [pab_pkg::BYTE_W-1:0] r_pool_len;
    pab_pkg::t_pab_cmd          cmd;
    pab_pkg::t_pab_sts          sts;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pab_pkg::REG_POOL_LEN) ? 32'(r_pool_len) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_len <= pab_pkg::POOL_LEN_RST;
        end else if (psel && penable && pwrite && paddr[2] == pab_pkg::REG_POOL_LEN) begin
            r_pool_len <= pwdata[pab_pkg::BYTE_W-1:0];
        end
    end

    pab_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pab_dp #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .LIVE_ENTRIES (LIVE_ENTRIES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_word   (i_in_word),
        .i_pool_len  (r_pool_len),
        .o_out_word  (o_out_word)
    );

endmodule

>>> tb/sv/pool_allocator_best_fit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_allocator_best_fit_test
// Drives allocate/free words into the best-fit pool allocator, predicts each
// grant or free status from a local copy of the pool tables, and checks
// every output word in order across several pool sizes.
// ----------------------------------------------------------------------------
module pool_allocator_best_fit_test;

    localparam int NTAB      = 32;
    localparam int POOL_CAP  = 1 << pab_pkg::OFFSET_BITS_DEF;
    localparam int MAX_CYC   = 1500000;
    localparam int TAIL_CYC  = 120;

    typedef struct {
        bit      valid;
        longint  offset;
        longint  size;
    } t_blk;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       in_valid = 0;
    logic       out_stall = 0;
    pab_pkg::t_in_word   in_word = '0;
    logic       o_in_stall;
    logic       o_out_valid;
    pab_pkg::t_out_word  o_out_word;
    logic       psel = 0, penable = 0, pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic       pready;

    pool_allocator_best_fit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall), .i_in_word(in_word),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // allocator mirror
    longint     pool_bytes;
    longint     bump_top;
    t_blk       freed_blk [NTAB];
    t_blk       live_blk [NTAB];
    pab_pkg::t_out_word  expected_q[$];
    pab_pkg::t_in_word   pending_q[$];
    int         fails = 0;
    int         cyc = 0;
    bit         calm = 0;      // no idling
    bit         hold_rx = 0;   // long receiver hold-off
    int         tx_gap = 0, rx_gap = 0;

    function automatic longint pool_lim();
        return (pool_bytes < POOL_CAP) ? pool_bytes : POOL_CAP;
    endfunction

    function automatic pab_pkg::t_out_word predict_word(pab_pkg::t_in_word w);
        pab_pkg::t_out_word r;
        longint    need, al, off;
        int        f, l, e;
        r.granted_offset = '0;
        if (w.func == pab_pkg::FUNC_ALLOC) begin
            if (w.byte_count == 0) begin
                r.status = pab_pkg::ST_ZERO;
            end else begin
                al = (w.align == 0) ? 1 : w.align;
                need = (longint'(w.byte_count) + al - 1) / al * al;
                f = -1;
                for (int i = 0; i < NTAB; i++) begin
                    if (freed_blk[i].valid && freed_blk[i].size >= need &&
                        (f < 0 || freed_blk[i].size < freed_blk[f].size ||
                         (freed_blk[i].size == freed_blk[f].size &&
                          freed_blk[i].offset < freed_blk[f].offset)))
                        f = i;
                end
                if (f < 0 && bump_top + need > pool_lim()) begin
                    r.status = pab_pkg::ST_OOM;
                end else begin
                    off = (f >= 0) ? freed_blk[f].offset : bump_top;
                    l = -1; e = -1;
                    for (int i = 0; i < NTAB; i++) begin
                        if (live_blk[i].valid) begin
                            if (l < 0 && live_blk[i].offset == off) l = i;
                        end else if (e < 0) begin
                            e = i;
                        end
                    end
                    if (l < 0) l = e;
                    if (l < 0) begin
                        r.status = pab_pkg::ST_FULL;
                    end else begin
                        if (f >= 0) freed_blk[f].valid = 0;
                        else bump_top += need;
                        live_blk[l] = '{1, off, need};
                        r.granted_offset = off[pab_pkg::GOFF_W-1:0];
                        r.status = pab_pkg::ST_GRANTED;
                    end
                end
            end
        end else begin
            r.status = pab_pkg::ST_IGNORED;
            if (w.byte_count != 0 && w.block_offset < pool_lim()) begin
                l = -1;
                for (int i = 0; i < NTAB; i++)
                    if (l < 0 && live_blk[i].valid && live_blk[i].offset == w.block_offset)
                        l = i;
                if (l >= 0 && live_blk[l].size == w.byte_count) begin
                    f = -1; e = -1;
                    for (int i = 0; i < NTAB; i++) begin
                        if (freed_blk[i].valid) begin
                            if (f < 0 && freed_blk[i].offset == w.block_offset &&
                                freed_blk[i].size == w.byte_count) f = i;
                        end else if (e < 0) begin
                            e = i;
                        end
                    end
                    if (f < 0) f = e;
                    if (f < 0) begin
                        r.status = pab_pkg::ST_FULL;
                    end else begin
                        live_blk[l].valid = 0;
                        freed_blk[f] = '{1, w.block_offset, w.byte_count};
                        r.status = pab_pkg::ST_FREED;
                    end
                end
            end
        end
        return r;
    endfunction

    // driver: prediction happens at acceptance, so the mirror tracks real order
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            expected_q.push_back(predict_word(in_word));
            void'(pending_q.pop_front());
        end
        if (!i_rst_n) begin
            in_valid <= 0;
        end else if (!(in_valid && o_in_stall)) begin
            // slot free: offer next word or idle
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                in_valid <= 0;
            end else if (pending_q.size() > 0) begin
                if (!calm && $urandom_range(0, 9) == 0) begin
                    tx_gap <= $urandom_range(1, 15);
                    in_valid <= 0;
                end else begin
                    in_valid <= 1;
                    in_word <= pending_q[0];
                end
            end else begin
                in_valid <= 0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        pab_pkg::t_out_word e;
        cyc <= cyc + 1;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_q.size() == 0) begin
                $error("output word with nothing expected: %h", o_out_word);
                fails = fails + 1;
            end else begin
                e = expected_q.pop_front();
                if (o_out_word.status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_out_word.status);
                    fails = fails + 1;
                end
                if (o_out_word.granted_offset !== e.granted_offset) begin
                    $error("granted_offset expected %h actual %h",
                           e.granted_offset, o_out_word.granted_offset);
                    fails = fails + 1;
                end
            end
        end
        if (hold_rx) begin
            out_stall <= 1;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            out_stall <= 1;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap <= $urandom_range(0, 14);
            out_stall <= 1;
        end else begin
            out_stall <= 0;
        end
    end

    always @(posedge i_clk) begin
        if (cyc >= MAX_CYC) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);
    endtask

    task automatic write_pool_len(longint v);
        @(posedge i_clk);
        psel <= 1; pwrite <= 1; paddr <= {pab_pkg::REG_POOL_LEN, 2'b00}; pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        pool_bytes = v & 64'h1FFFFF;
    endtask

    function automatic pab_pkg::t_in_word make_word(bit fn, longint bc, longint al,
                                                    longint bo);
        pab_pkg::t_in_word w;
        w.func = fn;
        w.byte_count = bc[pab_pkg::BYTE_W-1:0];
        w.align = al[pab_pkg::ALIGN_W-1:0];
        w.block_offset = bo[pab_pkg::BYTE_W-1:0];
        return w;
    endfunction

    // frees are drawn from the mirror's live blocks, so they can match
    task automatic queue_random_live(int n, int max_bytes);
        pab_pkg::t_in_word w;
        int       k, nv;
        int       idx[$];
        for (int i = 0; i < n; i++) begin
            while (pending_q.size() > 2) @(posedge i_clk);
            idx = {};
            for (int j = 0; j < NTAB; j++) if (live_blk[j].valid) idx.push_back(j);
            nv = $urandom_range(0, 99);
            w = make_word(1'($urandom_range(0, 1)), $urandom_range(0, 1 << 21),
                          $urandom_range(0, 8191), $urandom_range(0, (1 << 21) - 1));
            if (nv < 20) begin
                // noise as drawn
            end else if (nv < 60 || idx.size() == 0) begin
                w.func = pab_pkg::FUNC_ALLOC;
                w.byte_count = pab_pkg::BYTE_W'($urandom_range(1, max_bytes));
                w.align = ($urandom_range(0, 3) == 0) ?
                          pab_pkg::ALIGN_W'($urandom_range(0, 8191)) :
                          pab_pkg::ALIGN_W'(1 << $urandom_range(0, 6));
            end else begin
                k = idx[$urandom_range(0, idx.size() - 1)];
                w.func = pab_pkg::FUNC_FREE;
                w.byte_count = pab_pkg::BYTE_W'(live_blk[k].size);
                w.block_offset = pab_pkg::BYTE_W'(live_blk[k].offset);
                if ($urandom_range(0, 9) == 0) w.byte_count = w.byte_count + 1'b1;
            end
            pending_q.push_back(w);
        end
    endtask

    initial begin
        for (int i = 0; i < NTAB; i++) begin
            freed_blk[i] = '{0, 0, 0};
            live_blk[i] = '{0, 0, 0};
        end
        pool_bytes = pab_pkg::POOL_LEN_RST;
        bump_top = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: zero requests, alignments, oversize, bad frees
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 0, 4, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 0, 0, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 1, 0, 21'h1FFFFF));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 5, 8, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 100, 4096, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 21'h1FFFFF, 13'h1FFF, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 1 << 20, 1, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 8, 0, 1));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 7, 0, 1));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 8, 13'h1FFF, 1));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 4096, 0, 8));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 3, 2, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 4096, 1, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 8, 0, 21'h1FFFFF));
        wait_drained();

        // pool size extremes: zero, one, full cap and beyond, shrunk below top
        write_pool_len(0);
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 1, 1, 0));
        pending_q.push_back(make_word(pab_pkg::FUNC_FREE, 8, 0, 0));
        wait_drained();
        write_pool_len(21'h1FFFFF);
        pending_q.push_back(make_word(pab_pkg::FUNC_ALLOC, 1 << 19, 1, 0));
        wait_drained();
        write_pool_len(1 << 20);
        queue_random_live(300, 64);
        wait_drained();

        // long receiver hold-off while sender keeps offering
        hold_rx = 1;
        fork
            queue_random_live(40, 128);
            begin
                repeat (400) @(posedge i_clk);
                hold_rx = 0;
            end
        join
        wait_drained();

        write_pool_len(1);
        queue_random_live(100, 4);
        wait_drained();
        write_pool_len(700);
        queue_random_live(300, 96);
        wait_drained();
        write_pool_len(pab_pkg::POOL_LEN_RST);
        queue_random_live(350, 2048);
        wait_drained();

        calm = 1;
        queue_random_live(250, 300);
        wait_drained();

        if (fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/core/pab_pkg.sv
rtl/core/pab_ctrl.sv
rtl/core/pab_dp.sv
rtl/core/pool_allocator_best_fit.sv
tb/sv/pool_allocator_best_fit_test.sv
